[src/eca_pkg.sv]
package eca_pkg;

  localparam int unsigned DefaultWidth = 16;
  localparam int unsigned OpWidth      = 3;

  localparam logic [OpWidth-1:0] OpAdd = 3'd0;
  localparam logic [OpWidth-1:0] OpSub = 3'd1;
  localparam logic [OpWidth-1:0] OpMul = 3'd2;
  localparam logic [OpWidth-1:0] OpDiv = 3'd3;
  localparam logic [OpWidth-1:0] OpRem = 3'd4;

endpackage

[src/eca_cell.sv]
// One bit step of the chain: a shift-add multiply step and a restoring
// divide step on the same word, registered toward the next cell.
module eca_cell import eca_pkg::*; #(
  parameter int unsigned Width = DefaultWidth,
  parameter int unsigned Step  = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [OpWidth-1:0]  op_i,
  input  logic [Width-1:0]    code_i,
  input  logic                neg_a_i,
  input  logic                neg_b_i,
  input  logic [Width-1:0]    ma_i,
  input  logic [Width-1:0]    mb_i,
  input  logic [Width-1:0]    prod_i,
  input  logic [Width-1:0]    quo_i,
  input  logic [Width-1:0]    rem_i,
  output logic                valid_o,
  output logic [OpWidth-1:0]  op_o,
  output logic [Width-1:0]    code_o,
  output logic                neg_a_o,
  output logic                neg_b_o,
  output logic [Width-1:0]    ma_o,
  output logic [Width-1:0]    mb_o,
  output logic [Width-1:0]    prod_o,
  output logic [Width-1:0]    quo_o,
  output logic [Width-1:0]    rem_o
);

  localparam int unsigned Bit = Width - 1 - Step;

  logic [Width-1:0] prod_d;
  logic [Width:0]   trial;
  logic [Width:0]   diff;
  logic [Width-1:0] rem_d;
  logic [Width-1:0] quo_d;
  logic             valid_q;
  logic [OpWidth-1:0] op_q;
  logic [Width-1:0] code_q, ma_q, mb_q, prod_q, quo_q, rem_q;
  logic             neg_a_q, neg_b_q;

  // Multiply: add the multiplicand shifted by this cell's bit of the multiplier.
  always_comb begin
    prod_d = prod_i;
    if (mb_i[Step]) begin
      prod_d = prod_i + (ma_i << Step);
    end
  end

  // Divide: bring down the next dividend bit, subtract when it fits.
  always_comb begin
    trial = {rem_i, ma_i[Bit]};
    diff  = trial - {1'b0, mb_i};
    quo_d = quo_i;
    if (!diff[Width]) begin
      rem_d      = diff[Width-1:0];
      quo_d[Bit] = 1'b1;
    end else begin
      rem_d = trial[Width-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q    <= op_i;
      code_q  <= code_i;
      neg_a_q <= neg_a_i;
      neg_b_q <= neg_b_i;
      ma_q    <= ma_i;
      mb_q    <= mb_i;
      prod_q  <= prod_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign code_o  = code_q;
  assign neg_a_o = neg_a_q;
  assign neg_b_o = neg_b_q;
  assign ma_o    = ma_q;
  assign mb_o    = mb_q;
  assign prod_o  = prod_q;
  assign quo_o   = quo_q;
  assign rem_o   = rem_q;

endmodule

[src/excess_code_alu.sv]
// Excess-coded ALU, operands and result in offset binary (value plus 2^(WIDTH-1)).
// Input channel s_axis: tuser carries the operation (0 add, 1 subtract,
// 2 multiply, 3 divide, 4 remainder, others give 0), tdata carries
// operand_a in the low half and operand_b above it. Output channel m_axis:
// tdata carries the coded result, one word per input word, in order.
// The word passes through WIDTH registered bit cells; the operand decode sits
// before the first cell and the re-encode after the last one.
// Throughput is one word per cycle: every cell advances each cycle in which
// the output register is empty or being taken.
// Division truncates toward zero, the remainder takes the dividend's sign;
// a zero divisor gives an all-ones quotient magnitude and the dividend as
// remainder.
// Stall: when m_axis_tready is low while the output holds a word, the
// whole chain holds and s_axis_tready falls; no word is lost.
// Reset: rst_ni clears all valid flags; the chain comes up empty.
module excess_code_alu import eca_pkg::*; #(
  parameter int unsigned WIDTH = DefaultWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: operand_a, operand_b (lowest bit up)
  input  logic [2*WIDTH-1:0]    s_axis_tdata,
  // tuser: req_type
  input  logic [OpWidth-1:0]    s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: result
  output logic [WIDTH-1:0]      m_axis_tdata
);

  localparam logic [WIDTH-1:0] TopBit = {1'b1, {(WIDTH-1){1'b0}}};

  logic                 en;
  logic [WIDTH-1:0]     a, b;
  logic [WIDTH:0]       valid_c;
  logic [OpWidth-1:0]   op_c    [WIDTH+1];
  logic [WIDTH-1:0]     code_c  [WIDTH+1];
  logic                 neg_a_c [WIDTH+1];
  logic                 neg_b_c [WIDTH+1];
  logic [WIDTH-1:0]     ma_c    [WIDTH+1];
  logic [WIDTH-1:0]     mb_c    [WIDTH+1];
  logic [WIDTH-1:0]     prod_c  [WIDTH+1];
  logic [WIDTH-1:0]     quo_c   [WIDTH+1];
  logic [WIDTH-1:0]     rem_c   [WIDTH+1];
  logic [WIDTH-1:0]     mag;
  logic                 neg;
  logic [WIDTH-1:0]     res_d;

  // Advance the chain unless the output word is stalled.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign a = s_axis_tdata[WIDTH-1:0];
  assign b = s_axis_tdata[2*WIDTH-1:WIDTH];

  assign valid_c[0] = s_axis_tvalid;

  // Decode at the chain head; add and subtract finish here and ride along.
  always_comb begin
    op_c[0]    = s_axis_tuser;
    neg_a_c[0] = !a[WIDTH-1];
    neg_b_c[0] = !b[WIDTH-1];
    ma_c[0]    = a[WIDTH-1] ? (a ^ TopBit) : (TopBit - a);
    mb_c[0]    = b[WIDTH-1] ? (b ^ TopBit) : (TopBit - b);
    prod_c[0]  = '0;
    quo_c[0]   = '0;
    rem_c[0]   = '0;
    case (s_axis_tuser)
      OpAdd:   code_c[0] = (a + b) ^ TopBit;
      OpSub:   code_c[0] = (a - b) ^ TopBit;
      default: code_c[0] = '0;
    endcase
  end

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    eca_cell #(.Width(WIDTH), .Step(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[i]),
      .op_i    (op_c[i]),
      .code_i  (code_c[i]),
      .neg_a_i (neg_a_c[i]),
      .neg_b_i (neg_b_c[i]),
      .ma_i    (ma_c[i]),
      .mb_i    (mb_c[i]),
      .prod_i  (prod_c[i]),
      .quo_i   (quo_c[i]),
      .rem_i   (rem_c[i]),
      .valid_o (valid_c[i+1]),
      .op_o    (op_c[i+1]),
      .code_o  (code_c[i+1]),
      .neg_a_o (neg_a_c[i+1]),
      .neg_b_o (neg_b_c[i+1]),
      .ma_o    (ma_c[i+1]),
      .mb_o    (mb_c[i+1]),
      .prod_o  (prod_c[i+1]),
      .quo_o   (quo_c[i+1]),
      .rem_o   (rem_c[i+1])
    );
  end

  // Re-encode the sign-magnitude result at the chain tail. The restoring
  // divider already yields all ones and the dividend for a zero divisor.
  always_comb begin
    mag = '0;
    neg = neg_a_c[WIDTH] != neg_b_c[WIDTH];
    case (op_c[WIDTH])
      OpMul: mag = prod_c[WIDTH];
      OpDiv: mag = quo_c[WIDTH];
      OpRem: begin
        mag = rem_c[WIDTH];
        neg = neg_a_c[WIDTH];
      end
      default: mag = '0;
    endcase
    case (op_c[WIDTH]) inside
      OpMul, OpDiv, OpRem: res_d = neg ? (TopBit - mag) : (TopBit + mag);
      default:             res_d = code_c[WIDTH];
    endcase
  end

  assign m_axis_tvalid = valid_c[WIDTH];
  assign m_axis_tdata  = res_d;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready not tied to output stall");
  a_accept_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> valid_c[1])
    else $error("accepted word missing in first cell");
`endif

endmodule

[bench/tb_excess_code_alu_checker.sv]
module tb_excess_code_alu_checker import eca_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,
  input  logic [OpWidth-1:0]  s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [15:0]         m_axis_tdata,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] SignBit = 16'h8000;

  logic [15:0] coded_results_q[$];
  int          fail_count;
  int          mismatch_count;

  assign fail_count_o = fail_count;
  assign pending_o    = coded_results_q.size();

  function automatic logic [15:0] mag_of(logic [15:0] code);
    if (code[15]) begin
      return code ^ SignBit;
    end
    return SignBit - code;
  endfunction

  function automatic logic [15:0] code_of(logic neg, logic [15:0] mag);
    return neg ? SignBit - mag : SignBit + mag;
  endfunction

  function automatic logic [15:0] alu_result(logic [OpWidth-1:0] op, logic [15:0] a,
                                             logic [15:0] b);
    logic        na;
    logic        nb;
    logic [15:0] ma;
    logic [15:0] mb;
    logic [31:0] prod;
    na = ~a[15];
    nb = ~b[15];
    ma = mag_of(a);
    mb = mag_of(b);
    prod = ma * mb;
    case (op)
      OpAdd: return (a + b) ^ SignBit;
      OpSub: return (a - b) ^ SignBit;
      OpMul: return code_of(na != nb, prod[15:0]);
      OpDiv: return code_of(na != nb, (mb == 0) ? 16'hFFFF : ma / mb);
      OpRem: return code_of(na, (mb == 0) ? ma : ma % mb);
      default: return 16'h0000;
    endcase
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      coded_results_q.delete();
      fail_count     <= 0;
      mismatch_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (coded_results_q.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("checker: unexpected word %h", m_axis_tdata);
        end else begin
          want = coded_results_q.pop_front();
          if (want !== m_axis_tdata) begin
            fail_count     <= fail_count + 1;
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
              $display("checker: result mismatch, expected %h got %h", want, m_axis_tdata);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        coded_results_q.push_back(alu_result(s_axis_tuser, s_axis_tdata[15:0],
                                             s_axis_tdata[31:16]));
      end
    end
  end
endmodule

[bench/tb_excess_code_alu.sv]
module tb_excess_code_alu import eca_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 800;
  localparam int WatchLimit  = 20000;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;
  logic [OpWidth-1:0] s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [15:0]        m_axis_tdata;
  int                 fail_count;
  int                 pending;
  int                 words_sent;
  int                 words_back;
  int                 idle_cycles;
  bit                 stim_done;

  excess_code_alu i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  tb_excess_code_alu_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one word after an optional random gap with valid low, then hold it until taken.
  task automatic send_word(logic [OpWidth-1:0] op, logic [15:0] a, logic [15:0] b,
                           bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // Bias operands toward the edges of the code space: zero, min, max, +-1.
  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h0000;
      2: return 16'hFFFF;
      3: return 16'h8001;
      4: return 16'h7FFF;
      5: return 16'(32'h8000 + $urandom_range(0, 15) - 32'd8);
      default: return 16'($urandom());
    endcase
  endfunction

  // Stimulus: directed corners first, then a random mix with random gaps between words.
  initial begin
    logic [15:0] corners [6];
    corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF, 16'h5A5A};
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpAdd;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (corners[i]) begin
      send_word(OpAdd, corners[i], corners[5 - i], 1'b0);
      send_word(OpSub, corners[i], corners[(i + 2) % 6], 1'b1);
    end
    // Divide by zero, min over minus one, remainder by zero, multiplies, unused codes.
    send_word(OpDiv, 16'h1234, 16'h8000, 1'b0);
    send_word(OpDiv, 16'hC000, 16'h8000, 1'b1);
    send_word(OpDiv, 16'h0000, 16'h7FFF, 1'b0);
    send_word(OpRem, 16'h3000, 16'h8000, 1'b1);
    send_word(OpRem, 16'h0000, 16'h8003, 1'b0);
    send_word(OpMul, 16'h0000, 16'h0000, 1'b0);
    send_word(OpMul, 16'hFFFF, 16'h7FFF, 1'b1);
    send_word(OpMul, 16'h8003, 16'h7FFB, 1'b0);
    send_word(3'd5, 16'hFFFF, 16'hFFFF, 1'b0);
    send_word(3'd6, 16'h1111, 16'h2222, 1'b1);
    send_word(3'd7, 16'h0000, 16'hFFFF, 1'b0);
    for (int n = 0; n < RandomWords; n++) begin
      send_word(($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4)),
                pick_code(), pick_code(), $urandom_range(0, 3) == 0);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls per word, one long hold-off while the sender streams.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (words_back == 300) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      words_back++;
    end
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    words_sent  = 0;
    words_back  = 0;
    stim_done   = 1'b0;
    fork
      begin
        wait (stim_done);
        while (pending != 0) @(posedge clk_i);
        repeat (40) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= WatchLimit);
        $display("tb: watchdog expired, %0d words still due", pending);
        $display("tb: failure");
        $finish;
      end
    join_any
    $display("tb: %0d words sent, %0d results taken, corners and all ops covered",
             words_sent, words_back);
    $display("tb: %0d failures counted", fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
